@@ hdl/prva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-rail vote arbiter package
// Sizes, field widths, status codes and the table row layout that are shared
// by the channel interfaces, the vote table and the top level.
// ----------------------------------------------------------------------------
package prva_pkg;

  // Table dimensions.
  localparam int NUM_PMICS   = 2;
  localparam int NUM_RAILS   = 8;
  localparam int NUM_SOURCES = 4;
  localparam int ENTRIES     = NUM_PMICS * NUM_RAILS;

  // Index widths sized to the table.
  localparam int ENTRY_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SRC_W      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int RAIL_IDX_W = (NUM_RAILS > 1) ? $clog2(NUM_RAILS) : 1;

  // Field widths of the transactions.
  localparam int FUNC_W      = 1;
  localparam int SOURCE_W    = 3;
  localparam int PMIC_W      = 2;
  localparam int RAIL_W      = 4;
  localparam int VOLT_W      = 24;
  localparam int COUNT_W     = 8;
  localparam int ADDR_CALC_W = PMIC_W + RAIL_W;

  // Limits used by the parameter check.
  localparam logic [SOURCE_W:0] SRC_LIMIT  = (SOURCE_W + 1)'(NUM_SOURCES);
  localparam logic [PMIC_W:0]   PMIC_LIMIT = (PMIC_W + 1)'(NUM_PMICS);
  localparam logic [RAIL_W:0]   RAIL_LIMIT = (RAIL_W + 1)'(NUM_RAILS);

  // Reset requests issue at most this many off commands.
  localparam int RESULT_LIMIT = 8;
  localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

  // Operation and status codes.
  localparam logic FUNC_VOTE  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [VOLT_W-1:0]  volt_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  localparam count_t COUNT_MAX = '1;

  // One table row: everything kept for one PMIC and rail.
  typedef struct packed {
    count_t [NUM_SOURCES-1:0] count;
    volt_t  [NUM_SOURCES-1:0] volt;
  } row_t;

  // Write port of the vote table.
  typedef struct packed {
    logic   en;
    entry_t addr;
    row_t   data;
  } tbl_wr_t;

  // Request payload.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SOURCE_W-1:0] source;
    logic [PMIC_W-1:0]   pmic_index;
    logic [RAIL_W-1:0]   rail;
    logic                request_on;
    volt_t               voltage;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic              status;
    logic [RAIL_W-1:0] out_rail;
    logic              rail_on;
    volt_t             out_voltage;
    logic              last;
  } rsp_t;

endpackage

@@ hdl/prva_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-rail vote arbiter channels
// Valid/ready channels for vote and reset requests and for rail commands.
// ----------------------------------------------------------------------------
interface prva_req_if;
  import prva_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prva_rsp_if;
  import prva_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/prva_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-rail vote table
// One row per PMIC and rail, holding every source's count and voltage.
// One write and one registered read per cycle; rows never written read as 0.
// ----------------------------------------------------------------------------
module prva_table (
  input  logic             clk,
  input  logic             rst,
  input  prva_pkg::entry_t rd_addr,
  output prva_pkg::row_t   rd_row,
  input  prva_pkg::tbl_wr_t wr
);
  import prva_pkg::*;

  row_t               mem [ENTRIES];
  logic [ENTRIES-1:0] row_valid;
  row_t               rd_data;
  logic               rd_valid;

  // Row storage with a registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data  <= mem[rd_addr];
    rd_valid <= row_valid[rd_addr];
  end

  // A row counts as written once; reset makes the whole table read as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

@@ hdl/power_rail_vote_arbiter.sv @@
`timescale 1ns / 1ps
// Sequence: a vote result is offered after acceptance through the steps read,
// update, highest voltage scan of one source per cycle, and result; a reset walks
// the rails, then emits off commands one rail per cycle unless the result register stalls.
// Requests are taken one at a time, each finished before the next is accepted,
// and any stall of the result register holds the sequence.
// Reset (rst) clears control state and row valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// Power-rail vote arbiter
// Keeps per-source vote counts and voltages for every PMIC rail in a table
// and answers vote and reset requests with rail on/off commands.
// ----------------------------------------------------------------------------
module power_rail_vote_arbiter (
  input logic        clk,
  input logic        rst,
  prva_req_if.sink   req,
  prva_rsp_if.source rsp
);
  import prva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_VMOD = 3'd2;
  localparam logic [2:0] S_VMAX = 3'd3;
  localparam logic [2:0] S_VOUT = 3'd4;
  localparam logic [2:0] S_RMOD = 3'd5;
  localparam logic [2:0] S_ROUT = 3'd6;

  localparam logic [SRC_W-1:0]      SRC_LAST  = SRC_W'(NUM_SOURCES - 1);
  localparam logic [RAIL_IDX_W-1:0] RAIL_LAST = RAIL_IDX_W'(NUM_RAILS - 1);
  localparam logic [EMIT_W-1:0]     EMIT_LAST = EMIT_W'(RESULT_LIMIT - 1);

  logic [2:0]            state;
  logic                  func_q;
  logic [SRC_W-1:0]      src_q;
  logic [PMIC_W-1:0]     pmic_q;
  logic [RAIL_W-1:0]     rail_q;
  logic                  on_q;
  volt_t                 volt_q;
  entry_t                entry_q;
  row_t                  row;
  logic [SRC_W-1:0]      scan;
  volt_t                 best;
  logic                  any_vote;
  logic [RAIL_IDX_W-1:0] rail_cnt;
  logic [NUM_RAILS-1:0]  pend;
  logic [EMIT_W-1:0]     emit_n;

  entry_t                rd_addr;
  row_t                  rd_row;
  tbl_wr_t               wr;
  row_t                  vote_row;
  row_t                  clr_row;
  count_t                cur_cnt;
  count_t                new_cnt;
  volt_t                 new_volt;
  logic                  had_votes;
  logic                  left_any;
  logic                  bad_req;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  rsp_t                  out_next;
  logic [NUM_RAILS-1:0]  pend_rest;
  logic                  emit_last;
  logic [RAIL_W-1:0]     rail_next;

  // Row address of a PMIC and rail.
  function automatic entry_t entry_of(input logic [PMIC_W-1:0] p,
                                      input logic [RAIL_W-1:0] r);
    logic [ADDR_CALC_W-1:0] sum;
    sum = ({{(ADDR_CALC_W - PMIC_W){1'b0}}, p} * ADDR_CALC_W'(NUM_RAILS))
          + {{(ADDR_CALC_W - RAIL_W){1'b0}}, r};
    return sum[ENTRY_W-1:0];
  endfunction

  prva_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr      (wr)
  );

  // Handshakes.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // Parameter check of an incoming request; reset requests ignore the rail.
  assign bad_req = ({1'b0, req.data.source} >= SRC_LIMIT) ||
                   ({1'b0, req.data.pmic_index} >= PMIC_LIMIT) ||
                   ((req.data.func == FUNC_VOTE) && ({1'b0, req.data.rail} >= RAIL_LIMIT));

  // Table read address: the requested row on acceptance, the next rail while
  // a reset walks the PMIC. Every write of a request ends before the next
  // request is taken, so a read never meets a pending write to its row.
  assign rail_next = RAIL_W'(rail_cnt) + RAIL_W'(1);
  always_comb begin
    if (state == S_RMOD) begin
      rd_addr = entry_of(pmic_q, rail_next);
    end else if (req.data.func == FUNC_RESET) begin
      rd_addr = entry_of(req.data.pmic_index, '0);
    end else begin
      rd_addr = entry_of(req.data.pmic_index, req.data.rail);
    end
  end

  // Vote update of the row just read.
  assign cur_cnt = rd_row.count[src_q];
  always_comb begin
    vote_row = rd_row;
    if (on_q) begin
      new_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + count_t'(1);
      new_volt = volt_q;
    end else begin
      new_cnt  = (cur_cnt == '0) ? cur_cnt : cur_cnt - count_t'(1);
      new_volt = rd_row.volt[src_q];
    end
    if (new_cnt == '0) begin
      new_volt = '0;
    end
    vote_row.count[src_q] = new_cnt;
    vote_row.volt[src_q]  = new_volt;
  end

  // Reset update: drop all of the source's votes on the row just read.
  always_comb begin
    clr_row              = rd_row;
    clr_row.count[src_q] = '0;
    clr_row.volt[src_q]  = '0;
  end
  assign had_votes = (rd_row.count[src_q] != '0);
  assign left_any  = (clr_row.count != '0);

  // Write back.
  always_comb begin
    wr.en   = (state == S_VMOD) || ((state == S_RMOD) && had_votes);
    wr.addr = entry_q;
    wr.data = (state == S_VMOD) ? vote_row : clr_row;
  end

  // Pending off commands after the current rail.
  always_comb begin
    pend_rest           = pend;
    pend_rest[rail_cnt] = 1'b0;
  end
  assign emit_last = (pend_rest == '0) || (emit_n == EMIT_LAST);

  // Result to be loaded into the output register.
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    case (state)
      S_ERR: begin
        out_load             = out_free;
        out_next.status      = STATUS_BAD;
        out_next.out_rail    = (func_q == FUNC_RESET) ? '0 : rail_q;
        out_next.last        = 1'b1;
      end
      S_VOUT: begin
        out_load             = out_free;
        out_next.status      = STATUS_OK;
        out_next.out_rail    = rail_q;
        out_next.rail_on     = any_vote;
        out_next.out_voltage = any_vote ? best : volt_q;
        out_next.last        = 1'b1;
      end
      S_ROUT: begin
        out_load             = out_free && pend[rail_cnt];
        out_next.status      = STATUS_OK;
        out_next.out_rail    = RAIL_W'(rail_cnt);
        out_next.last        = emit_last;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.data <= out_next;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (bad_req) begin
              state <= S_ERR;
            end else if (req.data.func == FUNC_VOTE) begin
              state <= S_VMOD;
            end else begin
              state <= S_RMOD;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_VMOD: begin
          state <= S_VMAX;
        end
        S_VMAX: begin
          if (scan == SRC_LAST) begin
            state <= S_VOUT;
          end
        end
        S_VOUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_RMOD: begin
          if (rail_cnt == RAIL_LAST) begin
            state <= S_ROUT;
          end
        end
        S_ROUT: begin
          if (pend == '0) begin
            state <= S_IDLE;
          end else if (out_load && emit_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields and the working registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          func_q   <= req.data.func;
          src_q    <= SRC_W'(req.data.source);
          pmic_q   <= req.data.pmic_index;
          rail_q   <= req.data.rail;
          on_q     <= req.data.request_on;
          volt_q   <= req.data.voltage;
          entry_q  <= rd_addr;
          rail_cnt <= '0;
          pend     <= '0;
        end
      end
      S_VMOD: begin
        row      <= vote_row;
        scan     <= '0;
        best     <= '0;
        any_vote <= 1'b0;
      end
      S_VMAX: begin
        // One source per cycle: highest voltage among the voting sources.
        if (row.count[scan] != '0) begin
          any_vote <= 1'b1;
          if (row.volt[scan] > best) begin
            best <= row.volt[scan];
          end
        end
        if (scan != SRC_LAST) begin
          scan <= scan + SRC_W'(1);
        end
      end
      S_RMOD: begin
        // Mark a rail that lost its last vote for an off command.
        if (had_votes && !left_any) begin
          pend[rail_cnt] <= 1'b1;
        end
        entry_q <= rd_addr;
        if (rail_cnt == RAIL_LAST) begin
          rail_cnt <= '0;
          emit_n   <= '0;
        end else begin
          rail_cnt <= rail_cnt + RAIL_IDX_W'(1);
        end
      end
      S_ROUT: begin
        if (pend[rail_cnt]) begin
          if (out_load) begin
            pend[rail_cnt] <= 1'b0;
            emit_n         <= emit_n + EMIT_W'(1);
            rail_cnt       <= rail_cnt + RAIL_IDX_W'(1);
          end
        end else begin
          rail_cnt <= rail_cnt + RAIL_IDX_W'(1);
        end
      end
      default: begin
        row <= row;
      end
    endcase
  end

endmodule
